@@ rtl/rdsc_pkg.sv @@
// shared types, constants and the digit-to-ascii function of the radix
// digit string converter; no dependencies
package rdsc_pkg;

  localparam int DIGIT_W   = 4;   // one digit in radix up to sixteen
  localparam int RADIX_W   = 5;
  localparam int CHAR_W    = 7;
  localparam int STEP_BITS = 8;   // dividend bits retired per divide step

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;  // 'A'
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PRIME,
    ST_EMIT
  } conv_state_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end else begin
      return CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_W'(d - DIGIT_TEN)};
    end
  endfunction

endpackage

@@ rtl/rdsc_div_step.sv @@
// shared divide unit: restoring division of STEP_BITS dividend bits by the radix
// depends on rdsc_pkg
module rdsc_div_step import rdsc_pkg::*; (
  input  logic [DIGIT_W-1:0]   rem_in,
  input  logic [STEP_BITS-1:0] bits_in,
  input  logic [RADIX_W-1:0]   radix,
  output logic [STEP_BITS-1:0] quot,
  output logic [DIGIT_W-1:0]   rem_out
);

  always_comb begin
    logic [RADIX_W-1:0] part;
    logic [DIGIT_W-1:0] r;
    r    = rem_in;
    quot = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      part = {r, bits_in[i]};
      if (part >= radix) begin
        quot[i] = 1'b1;
        r       = DIGIT_W'(part - radix);
      end else begin
        r       = part[DIGIT_W-1:0];
      end
    end
    rem_out = r;
  end

endmodule

@@ rtl/rdsc_digit_store.sv @@
// digit memory: one write port, one registered read port
// depends on rdsc_pkg
module rdsc_digit_store import rdsc_pkg::*; #(
  parameter int DEPTH = 31,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [DIGIT_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/radix_digit_string_converter_core.sv @@
// top level of the radix digit string converter: sequencer, divide datapath,
// digit memory; depends on rdsc_pkg, rdsc_div_step, rdsc_digit_store
//
// Converts a non-negative value of VALUE_BITS bits into its digit string in
// radix two through sixteen (a radix below two is taken as two, above sixteen
// as sixteen). An item transfers at a clock edge with start high and busy low.
// The value is divided by the radix over and over in one shared divide unit
// that retires eight dividend bits per cycle; each remainder goes into a
// small digit memory. Once the quotient reaches zero the digits are read back
// most significant first, one per cycle after a priming state that starts the
// registered memory read. The characters come out as ascii '0'-'9' and
// 'A'-'F', each on digit_char for exactly one cycle with digit_strobe high;
// last_digit marks the final one. The receiver cannot stall these transfers.
// busy stays high from the transfer of the item until the last character is out.
// A value of zero yields the single character '0'.
module radix_digit_string_converter_core import rdsc_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  busy,
  output logic                  digit_strobe,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last_digit
);

  // dividend is padded up to a whole number of divide steps
  localparam int NCH    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_W = NCH * STEP_BITS;
  localparam int CNT_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int AW     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CW     = $clog2(VALUE_BITS + 1);

  conv_state_t state, state_next;

  logic [WORK_W-1:0]  work;       // dividend, becomes quotient in place
  logic [DIGIT_W-1:0] rem;        // running remainder within a digit pass
  logic [RADIX_W-1:0] rdx;        // saturated radix
  logic [CNT_W-1:0]   chunk;      // divide step within the current digit
  logic [CW-1:0]      ndig;       // digits written so far
  logic [AW-1:0]      ptr;        // read address during emission
  logic [CW-1:0]      left;       // characters still to emit

  logic [STEP_BITS-1:0] step_quot;
  logic [DIGIT_W-1:0]   step_rem;
  logic [WORK_W-1:0]    work_shift;
  logic                 last_chunk;
  logic                 quot_zero;
  logic                 wr_en;
  logic                 rd_en;
  logic [DIGIT_W-1:0]   rd_data;
  logic [RADIX_W-1:0]   radix_sat;

  // shared divide unit works on the top byte of the dividend
  rdsc_div_step u_div_step (
    .rem_in  (rem),
    .bits_in (work[WORK_W-1 -: STEP_BITS]),
    .radix   (rdx),
    .quot    (step_quot),
    .rem_out (step_rem)
  );

  rdsc_digit_store #(
    .DEPTH (VALUE_BITS),
    .AW    (AW)
  ) u_digit_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ndig[AW-1:0]),
    .wr_data (step_rem),
    .rd_en   (rd_en),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  // quotient bits shift in from the bottom as dividend bits leave the top
  assign work_shift = (work << STEP_BITS) | WORK_W'(step_quot);
  assign last_chunk = (chunk == CNT_W'(NCH - 1));
  assign quot_zero  = (work_shift == '0);

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (last_chunk && quot_zero) state_next = ST_PRIME;
      end
      ST_PRIME: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (left == CW'(1)) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and memory strobes
  always_comb begin
    busy         = 1'b1;
    digit_strobe = 1'b0;
    last_digit   = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_DIVIDE: begin
        wr_en = last_chunk;
      end
      ST_PRIME: begin
        rd_en = 1'b1;
      end
      ST_EMIT: begin
        digit_strobe = 1'b1;
        last_digit   = (left == CW'(1));
        // no read past the least significant digit
        rd_en        = (left != CW'(1));
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign digit_char = digit_ascii(rd_data);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chunk <= '0;
      ndig  <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            chunk <= '0;
            ndig  <= '0;
          end
        end
        ST_DIVIDE: begin
          if (last_chunk) begin
            chunk <= '0;
            ndig  <= ndig + CW'(1);
            if (quot_zero) left <= ndig + CW'(1);
          end else begin
            chunk <= chunk + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          left <= left - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          work <= WORK_W'(value);
          rem  <= '0;
          rdx  <= radix_sat;
        end
      end
      ST_DIVIDE: begin
        work <= work_shift;
        // a fresh digit pass starts with a zero remainder
        rem  <= last_chunk ? '0 : step_rem;
        if (last_chunk && quot_zero) ptr <= ndig[AW-1:0];
      end
      ST_PRIME, ST_EMIT: begin
        ptr <= ptr - AW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ dv/radix_digit_string_converter_checker.sv @@
// digit string checker for the radix digit string converter: watches the item
// and character transfers, predicts each digit string and compares; uses rdsc_pkg
module rdsc_digit_checker import rdsc_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  digit_strobe,
  input  logic [CHAR_W-1:0]     digit_char,
  input  logic                  last_digit,
  output int                    fail_count,
  output int                    pending_chars
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_xfer_t;

  digit_xfer_t expected_chars[$];
  int          mismatch_count = 0;

  // divide down by the clamped radix, then queue characters msd first
  function automatic void predict_digit_string(input logic [VALUE_BITS-1:0] v,
                                               input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0]    base;
    logic [DIGIT_W-1:0]    digits[VALUE_BITS];
    logic [VALUE_BITS-1:0] rest;
    digit_xfer_t           x;
    int                    n;
    base = (r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r;
    rest = v;
    n = 0;
    do begin
      if (n < VALUE_BITS) begin
        digits[n] = DIGIT_W'(rest % base);
        n++;
      end
      rest = rest / base;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] < DIGIT_TEN) x.ch = CHAR_ZERO + CHAR_W'(digits[k]);
      else x.ch = CHAR_A + CHAR_W'(digits[k] - DIGIT_TEN);
      x.last = (k == 0);
      expected_chars.push_back(x);
    end
  endfunction

  function automatic void note_mismatch(input string what, input digit_xfer_t want,
                                        input digit_xfer_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] character mismatch (%s): expected char %h last %b, got char %h last %b",
               $time, what, want.ch, want.last, got.ch, got.last);
  endfunction

  always @(posedge clk) begin
    digit_xfer_t got;
    digit_xfer_t want;
    if (rst) begin
      expected_chars.delete();
    end else begin
      if (digit_strobe) begin
        got.ch   = digit_char;
        got.last = last_digit;
        if (expected_chars.size() == 0) begin
          note_mismatch("no character pending", '0, got);
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) note_mismatch("wrong field", want, got);
        end
      end
      if (start && !busy) predict_digit_string(value, radix);
    end
    fail_count    <= mismatch_count;
    pending_chars <= expected_chars.size();
  end

endmodule

@@ dv/radix_digit_string_converter_core_tb.sv @@
// testbench top for radix_digit_string_converter_core: drives conversion
// requests with random gaps and gives the verdict; uses rdsc_pkg and rdsc_digit_checker
module radix_digit_string_converter_core_tb;
  import rdsc_pkg::*;

  localparam int VALUE_BITS   = 31;
  localparam int RANDOM_ITEMS = 420;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [VALUE_BITS-1:0] value = '0;
  logic [RADIX_W-1:0]    radix = '0;
  logic                  busy;
  logic                  digit_strobe;
  logic [CHAR_W-1:0]     digit_char;
  logic                  last_digit;

  int fail_count;
  int pending_chars;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  radix_digit_string_converter_core #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .value        (value),
    .radix        (radix),
    .busy         (busy),
    .digit_strobe (digit_strobe),
    .digit_char   (digit_char),
    .last_digit   (last_digit)
  );

  rdsc_digit_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .radix         (radix),
    .digit_strobe  (digit_strobe),
    .digit_char    (digit_char),
    .last_digit    (last_digit),
    .fail_count    (fail_count),
    .pending_chars (pending_chars)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 12);
    return $urandom_range(20, 160);
  endfunction

  // random bit length first so that short digit strings are common
  function automatic logic [VALUE_BITS-1:0] random_value();
    int                    len;
    logic [VALUE_BITS-1:0] v;
    len = $urandom_range(0, VALUE_BITS);
    v = VALUE_BITS'($urandom);
    if (len < VALUE_BITS) v = v & ((VALUE_BITS'(1) << len) - 1'b1);
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(0, 99) < 85) return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    return RADIX_W'($urandom_range(0, 31));
  endfunction

  // hold the request until the transfer, then idle for a random gap
  task automatic send_conversion(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r);
    int gap;
    value <= v;
    radix <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // start is only still high right after a transfer, so the wait below
  // always moves past this time step before the next request
  task automatic drain_results();
    if (start) start <= 1'b0;
    while (pending_chars != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero in every radix corner, including saturated ones
    send_conversion('0, RADIX_MIN);
    send_conversion('0, RADIX_MAX);
    send_conversion('0, 5'd0);
    send_conversion('0, 5'd1);
    send_conversion('0, 5'd17);
    send_conversion('0, 5'd31);
    // full width value: longest string in binary, shortest in hex
    send_conversion(VALUE_MAX, RADIX_MIN);
    send_conversion(VALUE_MAX, RADIX_MAX);
    send_conversion(VALUE_MAX, 5'd10);
    send_conversion(VALUE_MAX, 5'd0);
    send_conversion(VALUE_MAX, 5'd31);
    send_conversion(VALUE_MAX, 5'd3);
    send_conversion(VALUE_BITS'(1), RADIX_MIN);
    send_conversion(VALUE_BITS'(6), 5'd1);
    send_conversion(VALUE_BITS'(300), 5'd20);
    send_conversion(VALUE_BITS'(9), 5'd10);
    send_conversion(VALUE_BITS'(10), 5'd10);
    send_conversion(VALUE_BITS'(10), RADIX_MAX);
    send_conversion(VALUE_BITS'(255), RADIX_MAX);
    send_conversion(VALUE_BITS'(256), RADIX_MAX);
    send_conversion(VALUE_BITS'(32'h5555_5555), 5'd4);
    send_conversion(VALUE_BITS'(12345678), 5'd7);
    send_conversion(VALUE_BITS'(14), 5'd15);

    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_conversion(random_value(), random_radix());
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rdsc_pkg.sv
rtl/rdsc_div_step.sv
rtl/rdsc_digit_store.sv
rtl/radix_digit_string_converter_core.sv
dv/radix_digit_string_converter_checker.sv
dv/radix_digit_string_converter_core_tb.sv
